>>> design/hws_pkg.sv
package hws_pkg;

	localparam int CHANNELS    = 16;
	localparam int COUNT_WIDTH = 16;
	localparam int MASK_WIDTH  = 16;
	localparam int CHAN_WIDTH  = 5;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	typedef logic [COUNT_WIDTH-1:0] count_t;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SUPERVISE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHAN_EN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FEED_REQ  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SOFT      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HARD      = 3'd4;

	localparam logic [MASK_WIDTH-1:0] CHAN_EN_RST  = 16'd1;
	localparam logic [MASK_WIDTH-1:0] FEED_REQ_RST = 16'd31;
	localparam logic [15:0]           SOFT_RST     = 16'd60;
	localparam logic [15:0]           HARD_RST     = 16'd60;

	// shared controls broadcast to every cell
	typedef struct packed {
		logic   tick;
		logic   supervise;
		count_t soft_val;
	} cell_ctrl_t;

	function automatic count_t fit_count(input logic [15:0] v);
		return count_t'(v);
	endfunction

endpackage

>>> design/heartbeat_watchdog_supervisor.sv
// channel   signals                                   direction
// input     in_valid/in_ready: cmd, channel, status_ok into block
// output    out_valid/out_ready: restart_mask,        out of block
//           feed_pulse, hard_count
// config    cfg_we, cfg_index, cfg_data               into block
// on each transfer all channel cells update in parallel, and the result lands
// in the output register on the same edge.
// a new item is taken each cycle while the output register is empty or drained.
// reset loads every counter with 60 and the registers with their defaults.
// a stalled output holds the input off; nothing else stalls.
module heartbeat_watchdog_supervisor (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                cmd,
	input  logic [4:0]                          channel,
	input  logic                                status_ok,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [15:0]                         restart_mask,
	output logic                                feed_pulse,
	output logic [15:0]                         hard_count,
	input  logic                                cfg_we,
	input  logic [hws_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [hws_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import hws_pkg::*;

	logic                  supervise_q;
	logic [MASK_WIDTH-1:0] chan_en_q;
	logic [MASK_WIDTH-1:0] feed_req_q;
	logic [15:0]           soft_q;
	logic [15:0]           hard_rel_q;
	count_t                hard_q;

	logic                  step;
	logic                  tick;
	cell_ctrl_t            ctrl;
	logic [CHANNELS:0]     alive;
	logic [CHANNELS-1:0]   restart_vec;
	logic [15:0]           restart_out;
	count_t                hard_dec;
	count_t                hard_nxt;
	logic                  feed_nxt;

	logic                  out_valid_q;
	logic [15:0]           restart_q;
	logic                  feed_q;
	logic [15:0]           hard_count_q;

	assign in_ready = !out_valid_q || out_ready;
	assign step = in_valid && in_ready;
	assign tick = (cmd == 1'b0);

	assign ctrl.tick      = tick;
	assign ctrl.supervise = supervise_q;
	assign ctrl.soft_val  = fit_count(soft_q);

	assign alive[0] = 1'b1;

	for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
		logic hb_hit;
		logic en_bit;
		logic req_bit;
		assign hb_hit = cmd && status_ok && (32'(channel) == i);
		if (i < MASK_WIDTH) begin : g_mask
			assign en_bit  = chan_en_q[i];
			assign req_bit = feed_req_q[i];
		end else begin : g_nomask
			assign en_bit  = 1'b0;
			assign req_bit = 1'b0;
		end
		hws_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (step),
			.ctrl      (ctrl),
			.hb_hit    (hb_hit),
			.chan_en   (en_bit),
			.feed_req  (req_bit),
			.alive_in  (alive[i]),
			.alive_out (alive[i+1]),
			.restart   (restart_vec[i])
		);
	end

	for (genvar j = 0; j < 16; j++) begin : g_rmask
		if (j < CHANNELS) begin : g_on
			assign restart_out[j] = restart_vec[j];
		end else begin : g_off
			assign restart_out[j] = 1'b0;
		end
	end

	always_comb begin
		hard_dec = (hard_q != '0) ? hard_q - count_t'(1) : hard_q;
		hard_nxt = hard_q;
		feed_nxt = 1'b0;
		if (tick) begin
			hard_nxt = hard_dec;
			if (!supervise_q) begin
				feed_nxt = 1'b1;
			end else if (alive[CHANNELS]) begin
				feed_nxt = 1'b1;
				hard_nxt = fit_count(hard_rel_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			supervise_q <= 1'b1;
			chan_en_q   <= CHAN_EN_RST;
			feed_req_q  <= FEED_REQ_RST;
			soft_q      <= SOFT_RST;
			hard_rel_q  <= HARD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SUPERVISE: supervise_q <= cfg_data[0];
				REG_CHAN_EN:   chan_en_q   <= cfg_data[MASK_WIDTH-1:0];
				REG_FEED_REQ:  feed_req_q  <= cfg_data[MASK_WIDTH-1:0];
				REG_SOFT:      soft_q      <= cfg_data[15:0];
				REG_HARD:      hard_rel_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hard_q      <= fit_count(HARD_RST);
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				hard_q      <= hard_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, loaded on each input transfer
	always_ff @(posedge clk) begin
		if (step) begin
			restart_q    <= restart_out;
			feed_q       <= feed_nxt;
			hard_count_q <= 16'(hard_nxt);
		end
	end

	assign out_valid    = out_valid_q;
	assign restart_mask = restart_q;
	assign feed_pulse   = feed_q;
	assign hard_count   = hard_count_q;

endmodule

>>> design/hws_cell.sv
module hws_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  hws_pkg::cell_ctrl_t ctrl,
	input  logic               hb_hit,
	input  logic               chan_en,
	input  logic               feed_req,
	input  logic               alive_in,
	output logic               alive_out,
	output logic               restart
);
	import hws_pkg::*;

	count_t cnt_q;
	count_t dec;
	count_t nxt;

	always_comb begin
		dec = (cnt_q != '0) ? cnt_q - count_t'(1) : cnt_q;
		restart = 1'b0;
		nxt = cnt_q;
		if (ctrl.tick) begin
			restart = ctrl.supervise && chan_en && (dec == '0);
			nxt = restart ? ctrl.soft_val : dec;
		end else if (hb_hit) begin
			nxt = ctrl.soft_val;
		end
	end

	// feed chain: a required channel left at zero breaks it
	assign alive_out = alive_in && !(feed_req && (nxt == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= fit_count(SOFT_RST);
		end else if (step) begin
			cnt_q <= nxt;
		end
	end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import hws_pkg::*;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_BEAT = 1'b1;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS   = 48;
	localparam int SETTLE_CYCLES = 3;

	typedef struct packed {
		logic       cmd;
		logic [4:0] channel;
		logic       status_ok;
	} beat_item_t;

	typedef struct packed {
		logic [15:0] restart_mask;
		logic        feed_pulse;
		logic [15:0] hard_count;
	} wd_result_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
	} reg_write_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic cmd = 1'b0;
	logic [4:0] channel = '0;
	logic status_ok = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [15:0] restart_mask;
	logic feed_pulse;
	logic [15:0] hard_count;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	heartbeat_watchdog_supervisor u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.channel(channel),
		.status_ok(status_ok),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.restart_mask(restart_mask),
		.feed_pulse(feed_pulse),
		.hard_count(hard_count),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// watchdog shadow state and register copies
	count_t      chan_cnt [CHANNELS];
	count_t      hard_cnt;
	logic        sup_en;
	logic [15:0] chan_en;
	logic [15:0] feed_req;
	logic [15:0] soft_rl;
	logic [15:0] hard_rl;

	beat_item_t  pending_items [$];
	wd_result_t  expected_results [$];
	reg_write_t  reg_writes [$];
	beat_item_t  held_item;
	int unsigned send_gap = 0;
	int unsigned recv_stall = 0;
	int unsigned cycle_count = 0;
	int unsigned mismatch_count = 0;
	bit          calm = 1'b0;

	function automatic wd_result_t advance_watchdog(input beat_item_t it);
		wd_result_t r;
		bit alive;
		r = '0;
		if (it.cmd == CMD_BEAT) begin
			if (it.channel < CHANNELS && it.status_ok)
				chan_cnt[it.channel] = count_t'(soft_rl);
		end else begin
			if (hard_cnt != 0)
				hard_cnt = hard_cnt - 1'b1;
			for (int i = 0; i < CHANNELS; i++)
				if (chan_cnt[i] != 0)
					chan_cnt[i] = chan_cnt[i] - 1'b1;
			if (sup_en) begin
				for (int i = 0; i < CHANNELS; i++) begin
					if (chan_en[i] && chan_cnt[i] == 0) begin
						r.restart_mask[i] = 1'b1;
						chan_cnt[i] = count_t'(soft_rl);
					end
				end
				alive = 1'b1;
				for (int i = 0; i < CHANNELS; i++)
					if (feed_req[i] && chan_cnt[i] == 0)
						alive = 1'b0;
				if (alive) begin
					hard_cnt = count_t'(hard_rl);
					r.feed_pulse = 1'b1;
				end
			end else begin
				// fed but not reloaded while supervision is off
				r.feed_pulse = 1'b1;
			end
		end
		r.hard_count = 16'(hard_cnt);
		return r;
	endfunction

	// mostly short gaps, a few long ones, none at all in calm phases
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready)
				expected_results.push_back(advance_watchdog(held_item));
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					held_item = pending_items.pop_front();
					cmd <= held_item.cmd;
					channel <= held_item.channel;
					status_ok <= held_item.status_ok;
					in_valid <= 1'b1;
					send_gap = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		wd_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_stall = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result transfer with nothing expected");
				end else begin
					want = expected_results.pop_front();
					if (restart_mask !== want.restart_mask)
						report_mismatch($sformatf("restart_mask got %h want %h",
							restart_mask, want.restart_mask));
					if (feed_pulse !== want.feed_pulse)
						report_mismatch($sformatf("feed_pulse got %b want %b",
							feed_pulse, want.feed_pulse));
					if (hard_count !== want.hard_count)
						report_mismatch($sformatf("hard_count got %h want %h",
							hard_count, want.hard_count));
				end
			end
			if (recv_stall != 0) begin
				recv_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				recv_stall = pick_gap();
			end
		end
	end

	task automatic queue_item(input logic c, input int unsigned ch, input logic ok);
		beat_item_t it;
		it.cmd = c;
		it.channel = 5'(ch);
		it.status_ok = ok;
		pending_items.push_back(it);
	endtask

	task automatic queue_reg(input int unsigned idx, input logic [15:0] val);
		reg_write_t w;
		w.idx = CFG_IDX_W'(idx);
		w.data = val;
		reg_writes.push_back(w);
	endtask

	task automatic flush_reg_writes();
		reg_write_t w;
		while (reg_writes.size() != 0) begin
			w = reg_writes.pop_front();
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= w.idx;
			cfg_data <= w.data;
			case (w.idx)
				REG_SUPERVISE: sup_en = w.data[0];
				REG_CHAN_EN:   chan_en = w.data;
				REG_FEED_REQ:  feed_req = w.data;
				REG_SOFT:      soft_rl = w.data;
				REG_HARD:      hard_rl = w.data;
				default: ;
			endcase
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic program_regs(input logic sup, input logic [15:0] chen, input logic [15:0] freq,
			input logic [15:0] soft_rel, input logic [15:0] hard_rel);
		queue_reg(REG_SUPERVISE, {15'd0, sup});
		queue_reg(REG_CHAN_EN, chen);
		queue_reg(REG_FEED_REQ, freq);
		queue_reg(REG_SOFT, soft_rel);
		queue_reg(REG_HARD, hard_rel);
		flush_reg_writes();
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [15:0] pick_reload();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 16'($urandom_range(1, 8));
		if (r < 75)
			return 16'($urandom_range(9, 100));
		if (r < 85)
			return 16'($urandom_range(0, 65535));
		if (r < 93)
			return 16'hFFFF;
		return 16'd0;
	endfunction

	function automatic logic [15:0] pick_mask();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return 16'h0000;
		if (r < 25)
			return 16'hFFFF;
		if (r < 60)
			return 16'($urandom_range(0, 65535) & $urandom_range(0, 65535));
		return 16'($urandom_range(0, 65535));
	endfunction

	task automatic queue_random_item();
		int unsigned r;
		int unsigned ch;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			queue_item(CMD_TICK, $urandom_range(0, 31), 1'($urandom_range(0, 1)));
		end else if (r < 90) begin
			// keep the required channels alive most of the time
			ch = $urandom_range(0, 15);
			if (feed_req != 0 && $urandom_range(0, 9) < 7)
				while (!feed_req[ch])
					ch = $urandom_range(0, 15);
			queue_item(CMD_BEAT, ch, $urandom_range(0, 9) != 0);
		end else if (r < 95) begin
			queue_item(CMD_BEAT, $urandom_range(16, 31), 1'($urandom_range(0, 1)));
		end else begin
			queue_item(CMD_BEAT, $urandom_range(0, 31), 1'b0);
		end
	endtask

	initial begin
		sup_en = 1'b1;
		chan_en = CHAN_EN_RST;
		feed_req = FEED_REQ_RST;
		soft_rl = SOFT_RST;
		hard_rl = HARD_RST;
		for (int i = 0; i < CHANNELS; i++)
			chan_cnt[i] = count_t'(SOFT_RST);
		hard_cnt = count_t'(HARD_RST);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset defaults: good, bad and unknown heartbeats
		queue_item(CMD_BEAT, 0, 1'b1);
		queue_item(CMD_BEAT, 4, 1'b0);
		queue_item(CMD_BEAT, 16, 1'b1);
		queue_item(CMD_BEAT, 31, 1'b1);
		queue_item(CMD_BEAT, 15, 1'b1);
		queue_item(CMD_TICK, 0, 1'b0);
		queue_item(CMD_BEAT, 31, 1'b0);
		queue_item(CMD_TICK, 31, 1'b1);
		drain();

		// writes past the last register must be ignored
		for (int k = int'(REG_HARD) + 1; k < (1 << CFG_IDX_W); k++)
			queue_reg(k, 16'hFFFF);
		flush_reg_writes();
		queue_item(CMD_TICK, 0, 1'b0);
		drain();

		// supervision off: feed each tick, hard counter counts down and is not reloaded
		program_regs(1'b0, 16'hFFFF, 16'hFFFF, 16'd2, 16'd1);
		repeat (4) queue_item(CMD_TICK, 0, 1'b0);
		queue_item(CMD_BEAT, 2, 1'b1);
		queue_item(CMD_TICK, 0, 1'b0);
		drain();

		// zero soft reload: an enabled channel that expires reloads zero and expires on each tick
		program_regs(1'b1, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
		queue_item(CMD_TICK, 0, 1'b0);
		queue_item(CMD_TICK, 0, 1'b0);
		queue_item(CMD_BEAT, 3, 1'b1);
		queue_item(CMD_TICK, 0, 1'b0);
		drain();

		// empty masks, widest soft reload, zero hard reload
		program_regs(1'b1, 16'h0000, 16'h0000, 16'hFFFF, 16'd0);
		queue_item(CMD_TICK, 0, 1'b0);
		queue_item(CMD_BEAT, 7, 1'b1);
		queue_item(CMD_TICK, 0, 1'b0);
		queue_item(CMD_BEAT, 0, 1'b0);
		drain();

		program_regs(1'b1, 16'h8001, 16'h8000, 16'd1, 16'd2);
		queue_item(CMD_TICK, 0, 1'b0);
		queue_item(CMD_TICK, 0, 1'b0);
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			calm = ($urandom_range(0, 3) == 0);
			program_regs($urandom_range(0, 4) != 0, pick_mask(), pick_mask(),
				pick_reload(), pick_reload());
			repeat (PHASE_ITEMS) queue_random_item();
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
